// ===== rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the stream find-and-replace unit
// Register indexes, field widths and the structs passed to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned CFG_IDX_W  = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES  = 2'd0,
    CFG_PATTERN_LEN    = 2'd1,
    CFG_REPLACE_BYTES  = 2'd2,
    CFG_REPLACE_LEN    = 2'd3
  } sfr_cfg_idx_e;

  // control of one window cell
  typedef struct packed {
    logic we;      // an input transfer updates the window
    logic sel;     // this cell takes the incoming byte
    logic shift;   // window drops its oldest byte
    logic active;  // cell lies inside the pattern length
  } sfr_win_ctl_t;

  // control of one output cell
  typedef struct packed {
    logic load;    // take a fresh result from the step logic
    logic shift;   // a result left through the output
  } sfr_emit_ctl_t;

  // one result on its way out
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              present;
    logic              last;
  } sfr_ent_t;

endpackage

`default_nettype wire

// ===== rtl/sfr_win_cell.sv =====
// ----------------------------------------------------------------------------
// sfr_win_cell: one byte of the match window
// Holds a byte, compares the window view against its pattern byte and takes
// its neighbour's byte when the window drops its oldest entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_win_cell
  import sfr_pkg::*;
(
  input  wire                 clk_i,
  input  sfr_win_ctl_t        ctl_i,
  input  wire  [BYTE_W-1:0]   text_i,
  input  wire  [BYTE_W-1:0]   pat_i,
  input  wire  [BYTE_W-1:0]   app_nxt_i,
  output logic [BYTE_W-1:0]   app_o,
  output logic                hit_o
);

  logic [BYTE_W-1:0] byte_q;
  logic [BYTE_W-1:0] byte_d;

  // window contents with this step's byte appended
  assign app_o = ctl_i.sel ? text_i : byte_q;
  assign hit_o = !ctl_i.active || (app_o == pat_i);

  assign byte_d = ctl_i.shift ? app_nxt_i : app_o;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      byte_q <= byte_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfr_emit_cell.sv =====
// ----------------------------------------------------------------------------
// sfr_emit_cell: one slot of the output line
// Loads a result from the step logic or moves one place towards the output.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_emit_cell
  import sfr_pkg::*;
(
  input  wire            clk_i,
  input  sfr_emit_ctl_t  ctl_i,
  input  sfr_ent_t       src_i,
  input  sfr_ent_t       nxt_i,
  output sfr_ent_t       ent_o
);

  sfr_ent_t ent_q;
  sfr_ent_t ent_d;

  // fresh load wins over the shift
  always_comb begin
    ent_d = ent_q;
    if (ctl_i.load) begin
      ent_d = src_i;
    end else if (ctl_i.shift) begin
      ent_d = nxt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

`default_nettype wire

// ===== rtl/stream_find_replace_unit.sv =====
// ----------------------------------------------------------------------------
// stream_find_replace_unit: streaming substring find and replace
// Replaces every leftmost, non-overlapping occurrence of a pattern in a byte
// stream with a replacement text.
// ----------------------------------------------------------------------------
// Text enters one byte per transfer on the slave side; tlast marks the final
// byte. A row of window cells holds the bytes not yet sent and compares them
// against the pattern in the cycle a byte arrives. Each input byte produces
// zero, one or several results, which are loaded into a row of output cells
// and leave one per cycle on the master side while m_axis_tready is high. The
// input is accepted while at most one result is waiting, so a byte that
// yields several results (a replacement, or the flush at the end of text)
// holds the input while the output row drains. tuser low marks an empty end
// marker, sent when the final byte yields no byte. Writing pattern_length
// drops the held window bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_replace_unit
  import sfr_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned REPLACE_MAX = 8
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // configuration
  input  wire                   cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [CFG_DATA_W-1:0] cfg_data_i,
  // text in
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire  [7:0]            s_axis_tdata,   // [7:0] text_byte
  input  wire                   s_axis_tlast,   // end_of_text
  // text out
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [7:0] out_byte
  output logic                  m_axis_tuser,   // [0] byte_present
  output logic                  m_axis_tlast    // last_of_text
);

  localparam int unsigned JOB_MAX = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
  localparam int unsigned DEPTH   = JOB_MAX + 1;
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned WCW     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // configuration registers
  logic [CFG_DATA_W-1:0] pat_q;
  logic [LEN_W-1:0]      pat_len_q;
  logic [CFG_DATA_W-1:0] rep_q;
  logic [LEN_W-1:0]      rep_len_q;

  logic [WCW-1:0] win_cnt_q, win_cnt_d;
  logic [CW-1:0]  emit_cnt_q, emit_cnt_d;

  logic [LEN_W-1:0] plen, rlen;
  logic             acc, pop, eot, full, match, use_rep, marker, base;
  logic [CW-1:0]    n_raw, n_job;

  logic [BYTE_W-1:0] app [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] hit;
  sfr_ent_t src [JOB_MAX];
  sfr_ent_t ent [DEPTH];

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q     <= '0;
      pat_len_q <= LEN_W'(1);
      rep_q     <= '0;
      rep_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (sfr_cfg_idx_e'(cfg_idx_i))
        CFG_PATTERN_BYTES: pat_q     <= cfg_data_i;
        CFG_PATTERN_LEN:   pat_len_q <= cfg_data_i[LEN_W-1:0];
        CFG_REPLACE_BYTES: rep_q     <= cfg_data_i;
        CFG_REPLACE_LEN:   rep_len_q <= cfg_data_i[LEN_W-1:0];
        default:           pat_q     <= pat_q;
      endcase
    end
  end

  // effective lengths, clipped to the build limits; a zero pattern length counts as one
  always_comb begin
    if (pat_len_q == '0) begin
      plen = LEN_W'(1);
    end else if (pat_len_q > LEN_W'(PATTERN_MAX)) begin
      plen = LEN_W'(PATTERN_MAX);
    end else begin
      plen = pat_len_q;
    end
    if (rep_len_q > LEN_W'(REPLACE_MAX)) begin
      rlen = LEN_W'(REPLACE_MAX);
    end else begin
      rlen = rep_len_q;
    end
  end

  // handshakes
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (emit_cnt_q <= CW'(1));
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign eot           = s_axis_tlast;

  // window cells
  assign full    = (LEN_W'(win_cnt_q) == plen - LEN_W'(1));
  assign match   = &hit;
  assign use_rep = full && match;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_win
    sfr_win_ctl_t      ctl;
    logic [BYTE_W-1:0] nxt;

    assign ctl.we     = acc;
    assign ctl.sel    = (LEN_W'(win_cnt_q) == LEN_W'(i));
    assign ctl.shift  = full && !match;
    assign ctl.active = (LEN_W'(i) < plen);

    if (i < PATTERN_MAX - 1) begin : g_mid
      assign nxt = app[i+1];
    end else begin : g_end
      assign nxt = app[i];
    end

    sfr_win_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .text_i    (s_axis_tdata),
      .pat_i     (pat_q[BYTE_W*i +: BYTE_W]),
      .app_nxt_i (nxt),
      .app_o     (app[i]),
      .hit_o     (hit[i])
    );
  end

  // held byte count
  always_comb begin
    win_cnt_d = win_cnt_q;
    if (use_rep || eot) begin
      win_cnt_d = '0;
    end else if (!full) begin
      win_cnt_d = win_cnt_q + WCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cnt_q <= '0;
    end else if (cfg_we_i && (sfr_cfg_idx_e'(cfg_idx_i) == CFG_PATTERN_LEN)) begin
      win_cnt_q <= '0;
    end else if (acc) begin
      win_cnt_q <= win_cnt_d;
    end
  end

  // number of results this byte causes
  always_comb begin
    if (use_rep) begin
      n_raw = CW'(rlen);
    end else if (full) begin
      n_raw = eot ? CW'(plen) : CW'(1);
    end else begin
      n_raw = eot ? (CW'(win_cnt_q) + CW'(1)) : '0;
    end
  end

  assign marker = eot && (n_raw == '0);
  assign n_job  = marker ? CW'(1) : n_raw;

  // results of this step, in output order
  for (genvar j = 0; j < JOB_MAX; j++) begin : g_src
    logic [BYTE_W-1:0] rep_b, win_b;

    if (j < REPLACE_MAX) begin : g_rep
      assign rep_b = rep_q[BYTE_W*j +: BYTE_W];
    end else begin : g_norep
      assign rep_b = '0;
    end

    if (j < PATTERN_MAX) begin : g_wb
      assign win_b = app[j];
    end else begin : g_nowb
      assign win_b = '0;
    end

    always_comb begin
      src[j].data    = use_rep ? rep_b : win_b;
      src[j].present = 1'b1;
      src[j].last    = eot && (CW'(j) == n_job - CW'(1));
      if (marker && (j == 0)) begin
        src[j].data    = '0;
        src[j].present = 1'b0;
        src[j].last    = 1'b1;
      end
    end
  end

  // output cells: new results go behind the one still waiting
  assign base = (emit_cnt_q == CW'(1)) && !pop;

  for (genvar i = 0; i < DEPTH; i++) begin : g_emit
    sfr_emit_ctl_t ctl;
    sfr_ent_t      ld, nxt, here;

    if (i < JOB_MAX) begin : g_here
      assign here = src[i];
    end else begin : g_nohere
      assign here = '0;
    end

    if (i >= 1) begin : g_behind
      assign ld = base ? src[i-1] : here;
    end else begin : g_front
      assign ld = here;
    end

    if (i < DEPTH - 1) begin : g_mid
      assign nxt = ent[i+1];
    end else begin : g_end
      assign nxt = ent[i];
    end

    assign ctl.load  = acc && ((i != 0) || !base);
    assign ctl.shift = pop;

    sfr_emit_cell u_cell (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .src_i (ld),
      .nxt_i (nxt),
      .ent_o (ent[i])
    );
  end

  // results waiting in the output cells
  always_comb begin
    emit_cnt_d = emit_cnt_q - (pop ? CW'(1) : CW'(0));
    if (acc) begin
      emit_cnt_d = emit_cnt_d + n_job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_cnt_q <= '0;
    end else begin
      emit_cnt_q <= emit_cnt_d;
    end
  end

  assign m_axis_tvalid = (emit_cnt_q != '0);
  assign m_axis_tdata  = ent[0].data;
  assign m_axis_tuser  = ent[0].present;
  assign m_axis_tlast  = ent[0].last;

endmodule

`default_nettype wire

// ===== rtl/sfr_checker.sv =====
// ----------------------------------------------------------------------------
// sfr_checker: port-level checks of the stream find-and-replace unit
// Watches the top-level ports and is bound to every instance of the unit.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_checker
  import sfr_pkg::*;
(
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  s_axis_tready,
  input wire                  m_axis_tvalid,
  input wire                  m_axis_tready,
  input wire [7:0]            m_axis_tdata,
  input wire                  m_axis_tuser,
  input wire                  m_axis_tlast
);

  // an empty marker only ever closes a text
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("empty marker without end flag");

  // an empty marker carries a zero byte
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == 8'd0))
    else $error("empty marker with non-zero byte");

  // with nothing waiting at the output, input is taken
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled output transfer changed");

endmodule

bind stream_find_replace_unit sfr_checker u_sfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
